// ----- design/parallel_flash_command_sequencer_core_defines.svh -----
// assertion macros for the flash command sequencer
// used by the top level only; expects clk and arst_n in scope
`ifndef PARALLEL_FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH
`define PARALLEL_FLASH_COMMAND_SEQUENCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// implication checked every clock outside reset
`define PFCS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define PFCS_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`else

`define PFCS_ASSERT(lbl, prop, msg)
`define PFCS_NEVER(lbl, cond, msg)

`endif

`endif

// ----- design/pfcs_pkg.sv -----
// shared types, constants and the result generator of the flash command sequencer
// no dependencies
package pfcs_pkg;

	localparam int SECTOR_BITS = 12;
	localparam int WINDOW_BITS = 14;

	localparam int ADDR_W = 19;

	localparam logic [ADDR_W-1:0] SECT_MASK = ADDR_W'((1 << SECTOR_BITS) - 1);
	localparam logic [ADDR_W-1:0] WIN_MASK  = ADDR_W'((1 << WINDOW_BITS) - 1);
	localparam logic [15:0]       CPU_BASE  = 16'hC000;

	localparam logic [ADDR_W-1:0] UNLOCK1_ADDR = 19'h05555;
	localparam logic [ADDR_W-1:0] UNLOCK2_ADDR = 19'h02AAA;
	localparam logic [ADDR_W-1:0] ID_MAKER_ADDR = 19'h00000;
	localparam logic [ADDR_W-1:0] ID_CHIP_ADDR  = 19'h00001;

	localparam logic [7:0] UNLOCK1_DATA = 8'hAA;
	localparam logic [7:0] UNLOCK2_DATA = 8'h55;
	localparam logic [7:0] ERASE_SETUP  = 8'h80;
	localparam logic [7:0] SECTOR_ERASE = 8'h30;
	localparam logic [7:0] BYTE_PROGRAM = 8'hA0;
	localparam logic [7:0] ID_ENTRY     = 8'h90;
	localparam logic [7:0] ID_EXIT      = 8'hF0;
	localparam logic [7:0] TOGGLE_MASK  = 8'h40;

	typedef enum logic [1:0] {
		CMD_PROGRAM = 2'd0,
		CMD_READ_ID = 2'd1,
		CMD_RETURN  = 2'd2
	} pfcs_cmd_e;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_DONE  = 2'd2
	} pfcs_kind_e;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ERASE,
		PH_PROG,
		PH_ID
	} pfcs_phase_e;

	// which burst of bus operations a command expands to
	typedef enum logic [2:0] {
		SEQ_NONE,
		SEQ_ERASE,
		SEQ_PROG,
		SEQ_ID_START,
		SEQ_ID_END,
		SEQ_POLL,
		SEQ_DONE
	} pfcs_seq_e;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [ADDR_W-1:0] flash_addr;
		logic [7:0]        data;
	} pfcs_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  bank;
		logic [15:0] cpu_addr;
		logic [7:0]  bus_data;
		logic [7:0]  maker_id;
		logic [7:0]  chip_id;
		logic        last;
	} pfcs_out_t;

	typedef struct packed {
		pfcs_seq_e         seq;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        wbyte;
		logic [7:0]        maker;
		logic [7:0]        chip;
	} pfcs_job_t;

	// one bus operation of a burst, picked by step
	function automatic pfcs_out_t pfcs_result(pfcs_job_t job, logic [2:0] step);
		pfcs_out_t         r;
		pfcs_kind_e        kind;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W-1:0] sh;
		logic [7:0]        wd;
		logic [7:0]        mk;
		logic [7:0]        ch;
		logic              lst;
		kind = KIND_WRITE;
		addr = UNLOCK1_ADDR;
		wd   = UNLOCK1_DATA;
		mk   = '0;
		ch   = '0;
		lst  = 1'b0;
		unique case (job.seq)
			SEQ_ERASE: begin
				unique case (step)
					3'd0, 3'd3: ;
					3'd1, 3'd4: begin
						addr = UNLOCK2_ADDR;
						wd   = UNLOCK2_DATA;
					end
					3'd2: wd = ERASE_SETUP;
					3'd5: begin
						addr = job.addr;
						wd   = SECTOR_ERASE;
					end
					3'd6, 3'd7: begin
						kind = KIND_READ;
						addr = job.addr;
						wd   = '0;
						lst  = step[0];
					end
				endcase
			end
			SEQ_PROG: begin
				unique case (step)
					3'd0: ;
					3'd1: begin
						addr = UNLOCK2_ADDR;
						wd   = UNLOCK2_DATA;
					end
					3'd2: wd = BYTE_PROGRAM;
					3'd3: begin
						addr = job.addr;
						wd   = job.wbyte;
					end
					default: begin
						kind = KIND_READ;
						addr = job.addr;
						wd   = '0;
						lst  = (step == 3'd5);
					end
				endcase
			end
			SEQ_ID_START: begin
				unique case (step)
					3'd0: ;
					3'd1: begin
						addr = UNLOCK2_ADDR;
						wd   = UNLOCK2_DATA;
					end
					3'd2: wd = ID_ENTRY;
					3'd3: begin
						kind = KIND_READ;
						addr = ID_MAKER_ADDR;
						wd   = '0;
					end
					default: begin
						kind = KIND_READ;
						addr = ID_CHIP_ADDR;
						wd   = '0;
						lst  = 1'b1;
					end
				endcase
			end
			SEQ_ID_END: begin
				unique case (step)
					3'd0: ;
					3'd1: begin
						addr = UNLOCK2_ADDR;
						wd   = UNLOCK2_DATA;
					end
					3'd2: wd = ID_EXIT;
					default: begin
						kind = KIND_DONE;
						wd   = '0;
						mk   = job.maker;
						ch   = job.chip;
						lst  = 1'b1;
					end
				endcase
			end
			SEQ_POLL: begin
				kind = KIND_READ;
				addr = job.addr;
				wd   = '0;
				lst  = step[0];
			end
			default: begin
				kind = KIND_DONE;
				wd   = '0;
				lst  = 1'b1;
			end
		endcase
		sh         = addr >> WINDOW_BITS;
		r.kind     = kind;
		r.bus_data = wd;
		r.maker_id = mk;
		r.chip_id  = ch;
		r.last     = lst;
		if (kind == KIND_DONE) begin
			r.bank     = '0;
			r.cpu_addr = CPU_BASE;
		end else begin
			r.bank     = sh[4:0];
			r.cpu_addr = 16'(addr & WIN_MASK) + CPU_BASE;
		end
		return r;
	endfunction

endpackage

// ----- design/pfcs_ctrl.sv -----
// command decode and sequencer state: phase, held address/byte, read pairing
// depends on pfcs_pkg
module pfcs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  pfcs_pkg::pfcs_in_t  item,
	output pfcs_pkg::pfcs_job_t job
);
	import pfcs_pkg::*;

	pfcs_phase_e       phase_q, phase_d;
	logic [ADDR_W-1:0] held_addr_q, held_addr_d;
	logic [7:0]        held_byte_q, held_byte_d;
	logic [7:0]        first_return_q, first_return_d;
	logic              return_count_q, return_count_d;

	logic idle;
	logic sector_start;
	logic toggling;
	logic is_prog, is_id, is_ret;

	assign idle         = (phase_q == PH_IDLE);
	assign sector_start = ((item.flash_addr & SECT_MASK) == '0);
	assign toggling     = ((first_return_q ^ item.data) & TOGGLE_MASK) != '0;
	assign is_prog      = (item.cmd == CMD_PROGRAM);
	assign is_id        = (item.cmd == CMD_READ_ID);
	assign is_ret       = (item.cmd == CMD_RETURN);

	// next state
	always_comb begin
		phase_d        = phase_q;
		held_addr_d    = held_addr_q;
		held_byte_d    = held_byte_q;
		first_return_d = first_return_q;
		return_count_d = return_count_q;
		if (take) begin
			if (idle) begin
				if (is_prog) begin
					held_addr_d    = item.flash_addr;
					held_byte_d    = item.data;
					phase_d        = sector_start ? PH_ERASE : PH_PROG;
					first_return_d = '0;
					return_count_d = 1'b0;
				end else if (is_id) begin
					phase_d        = PH_ID;
					first_return_d = '0;
					return_count_d = 1'b0;
				end
			end else if (is_ret) begin
				if (!return_count_q) begin
					first_return_d = item.data;
					return_count_d = 1'b1;
				end else begin
					// second return of a pair always restarts the pairing
					first_return_d = '0;
					return_count_d = 1'b0;
					priority if (phase_q == PH_ID) phase_d = PH_IDLE;
					else if (toggling)            phase_d = phase_q;
					else if (phase_q == PH_ERASE) phase_d = PH_PROG;
					else                          phase_d = PH_IDLE;
				end
			end
		end
	end

	// burst selection
	always_comb begin
		job.seq   = SEQ_NONE;
		job.addr  = held_addr_q;
		job.wbyte = held_byte_q;
		job.maker = '0;
		job.chip  = '0;
		if (idle) begin
			if (is_prog) begin
				job.seq   = sector_start ? SEQ_ERASE : SEQ_PROG;
				job.addr  = item.flash_addr;
				job.wbyte = item.data;
			end else if (is_id) begin
				job.seq = SEQ_ID_START;
			end
		end else if (is_ret && return_count_q) begin
			priority if (phase_q == PH_ID) begin
				job.seq   = SEQ_ID_END;
				job.maker = first_return_q;
				job.chip  = item.data;
			end else if (toggling) begin
				job.seq = SEQ_POLL;
			end else if (phase_q == PH_ERASE) begin
				job.seq = SEQ_PROG;
			end else begin
				job.seq = SEQ_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_IDLE;
			held_addr_q    <= '0;
			held_byte_q    <= '0;
			first_return_q <= '0;
			return_count_q <= 1'b0;
		end else begin
			phase_q        <= phase_d;
			held_addr_q    <= held_addr_d;
			held_byte_q    <= held_byte_d;
			first_return_q <= first_return_d;
			return_count_q <= return_count_d;
		end
	end

endmodule

// ----- design/pfcs_emit.sv -----
// burst register and step counter; drives one bus operation per transaction
// depends on pfcs_pkg
module pfcs_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  pfcs_pkg::pfcs_job_t job,
	output logic                free,
	output logic                res_valid,
	input  logic                res_ready,
	output pfcs_pkg::pfcs_out_t res_item
);
	import pfcs_pkg::*;

	pfcs_job_t  job_q;
	logic [2:0] step_q;
	logic       busy_q;
	logic       finishing;

	assign res_item  = pfcs_result(job_q, step_q);
	assign res_valid = busy_q;
	assign finishing = busy_q && res_ready && res_item.last;
	assign free      = !busy_q || finishing;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (load && job.seq != SEQ_NONE) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && res_ready) begin
			if (res_item.last) busy_q <= 1'b0;
			else step_q <= step_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && job.seq != SEQ_NONE) job_q <= job;
	end

endmodule

// ----- design/parallel_flash_command_sequencer_core.sv -----
// top level of the flash command sequencer: command decode feeding the burst emitter
// depends on pfcs_pkg, pfcs_ctrl, pfcs_emit and the assertion macro header
//
//   port group   direction   payload       handshake
//   cmd_*        in          pfcs_in_t     cmd_valid / cmd_ready
//   res_*        out         pfcs_out_t    res_valid / res_ready
//
// one command yields 0 to 8 bus operations, one per cycle while res_ready is high
// the next command is taken in the cycle the previous burst's last operation goes out
// a command that yields nothing leaves the emitter free; polling pace is set by the read returns
// reset clears the phase, held address/byte, read pairing and the emitter
// a stall on res_ready holds the current operation and blocks new commands
`include "parallel_flash_command_sequencer_core_defines.svh"

module parallel_flash_command_sequencer_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_ready,
	input  pfcs_pkg::pfcs_in_t  cmd_item,
	output logic                res_valid,
	input  logic                res_ready,
	output pfcs_pkg::pfcs_out_t res_item
);
	import pfcs_pkg::*;

	pfcs_job_t job;
	logic      take;
	logic      free;

	assign cmd_ready = free;
	assign take      = cmd_valid && cmd_ready;

	pfcs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (cmd_item),
		.job    (job)
	);

	pfcs_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take),
		.job       (job),
		.free      (free),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	`PFCS_ASSERT(a_ready_when_empty, !res_valid |-> cmd_ready, "command blocked with no burst")
	`PFCS_ASSERT(a_burst_continues, (res_valid && res_ready && !res_item.last) |=> res_valid, "burst ended without last")
	`PFCS_ASSERT(a_done_fields, (res_valid && res_item.kind == KIND_DONE) |-> (res_item.bank == '0 && res_item.cpu_addr == CPU_BASE && res_item.last), "bad done item")
	`PFCS_NEVER(a_window, res_valid && res_item.cpu_addr[15:14] != 2'b11, "cpu address outside window")

endmodule

// ----- tb/sv/pfcs_checker.sv -----
// result checker for the flash command sequencer: predicts the bus operations of every
// accepted command transaction and compares them in order with the result channel
// depends on pfcs_pkg only
module pfcs_checker
	import pfcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  logic      cmd_ready,
	input  pfcs_in_t  cmd_item,
	input  logic      res_valid,
	input  logic      res_ready,
	input  pfcs_out_t res_item,
	output int        mismatches,
	output int        pending
);
	timeunit 1ns;
	timeprecision 1ps;

	pfcs_phase_e       seq_phase;
	logic [ADDR_W-1:0] held_addr;
	logic [7:0]        held_byte;
	logic [7:0]        first_poll;
	logic              poll_half;
	pfcs_out_t         ops_due[$];
	pfcs_out_t         burst[$];

	function automatic pfcs_out_t bus_op(pfcs_kind_e kind, logic [ADDR_W-1:0] addr,
		logic [7:0] d, logic [7:0] mk, logic [7:0] ch);
		pfcs_out_t r;
		r = '0;
		r.kind = kind;
		if (kind == KIND_DONE) begin
			r.bank     = '0;
			r.cpu_addr = CPU_BASE;
		end else begin
			r.bank     = 5'(addr >> WINDOW_BITS);
			r.cpu_addr = CPU_BASE + 16'(addr[WINDOW_BITS-1:0]);
		end
		r.bus_data = d;
		r.maker_id = mk;
		r.chip_id  = ch;
		return r;
	endfunction

	function automatic string show(pfcs_out_t r);
		return $sformatf("kind %0d bank %0d cpu_addr %h data %h maker %h chip %h last %0d",
			r.kind, r.bank, r.cpu_addr, r.bus_data, r.maker_id, r.chip_id, r.last);
	endfunction

	task automatic wr(logic [ADDR_W-1:0] addr, logic [7:0] d);
		burst.push_back(bus_op(KIND_WRITE, addr, d, 8'h00, 8'h00));
	endtask

	task automatic unlock();
		wr(UNLOCK1_ADDR, UNLOCK1_DATA);
		wr(UNLOCK2_ADDR, UNLOCK2_DATA);
	endtask

	// status is read twice so the toggle bit can be compared
	task automatic poll();
		burst.push_back(bus_op(KIND_READ, held_addr, 8'h00, 8'h00, 8'h00));
		burst.push_back(bus_op(KIND_READ, held_addr, 8'h00, 8'h00, 8'h00));
		poll_half  = 1'b0;
		first_poll = 8'h00;
	endtask

	task automatic program_byte();
		unlock();
		wr(UNLOCK1_ADDR, BYTE_PROGRAM);
		wr(held_addr, held_byte);
		seq_phase = PH_PROG;
		poll();
	endtask

	task automatic finish_cmd(logic [7:0] mk, logic [7:0] ch);
		burst.push_back(bus_op(KIND_DONE, '0, 8'h00, mk, ch));
		poll_half  = 1'b0;
		first_poll = 8'h00;
		seq_phase  = PH_IDLE;
	endtask

	task automatic expand_command(pfcs_in_t it);
		pfcs_out_t tail;
		burst.delete();
		if (seq_phase == PH_IDLE) begin
			if (it.cmd == CMD_PROGRAM) begin
				held_addr = it.flash_addr;
				held_byte = it.data;
				// a sector start is erased before it is programmed
				if ((it.flash_addr & SECT_MASK) == '0) begin
					unlock();
					wr(UNLOCK1_ADDR, ERASE_SETUP);
					unlock();
					wr(it.flash_addr, SECTOR_ERASE);
					seq_phase = PH_ERASE;
					poll();
				end else begin
					program_byte();
				end
			end else if (it.cmd == CMD_READ_ID) begin
				unlock();
				wr(UNLOCK1_ADDR, ID_ENTRY);
				burst.push_back(bus_op(KIND_READ, ID_MAKER_ADDR, 8'h00, 8'h00, 8'h00));
				burst.push_back(bus_op(KIND_READ, ID_CHIP_ADDR, 8'h00, 8'h00, 8'h00));
				poll_half  = 1'b0;
				first_poll = 8'h00;
				seq_phase  = PH_ID;
			end
		end else if (it.cmd == CMD_RETURN) begin
			if (!poll_half) begin
				first_poll = it.data;
				poll_half  = 1'b1;
			end else if (seq_phase == PH_ID) begin
				unlock();
				wr(UNLOCK1_ADDR, ID_EXIT);
				finish_cmd(first_poll, it.data);
			end else if (((first_poll ^ it.data) & TOGGLE_MASK) != 8'h00) begin
				poll();
			end else if (seq_phase == PH_ERASE) begin
				program_byte();
			end else begin
				finish_cmd(8'h00, 8'h00);
			end
		end
		if (burst.size() > 0) begin
			tail = burst.pop_back();
			tail.last = 1'b1;
			burst.push_back(tail);
		end
		foreach (burst[i])
			ops_due.push_back(burst[i]);
	endtask

	task automatic check_result(pfcs_out_t got);
		pfcs_out_t want;
		if (ops_due.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("[%0t] result with nothing expected: %s", $realtime, show(got));
		end else begin
			want = ops_due.pop_front();
			if (got.kind !== want.kind || got.bank !== want.bank
				|| got.cpu_addr !== want.cpu_addr || got.bus_data !== want.bus_data
				|| got.maker_id !== want.maker_id || got.chip_id !== want.chip_id
				|| got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("[%0t] result mismatch", $realtime);
					$display("  expected %s", show(want));
					$display("  actual   %s", show(got));
				end
			end
		end
	endtask

	initial begin
		mismatches = 0;
		pending    = 0;
	end

	// results are matched before new commands are expanded: a command accepted at
	// this edge cannot have produced the result accepted at the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_phase  = PH_IDLE;
			held_addr  = '0;
			held_byte  = 8'h00;
			first_poll = 8'h00;
			poll_half  = 1'b0;
			ops_due.delete();
			pending    = 0;
		end else begin
			if (res_valid && res_ready)
				check_result(res_item);
			if (cmd_valid && cmd_ready)
				expand_command(cmd_item);
			pending = ops_due.size();
		end
	end

endmodule

// ----- tb/sv/tb_top.sv -----
// testbench top for the flash command sequencer: clock, reset, command and read-return
// stimulus, receiver stalls, watchdog and verdict
// depends on pfcs_pkg, pfcs_checker and parallel_flash_command_sequencer_core
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfcs_pkg::*;

	localparam int         ITEMS         = 360;
	localparam int         STALL_LIMIT   = 5000;
	localparam int         HOLD_CYCLES   = 300;
	localparam int         HOLD_AT       = 300;
	localparam int         SETTLE_CYCLES = 20;
	localparam logic [1:0] CMD_UNUSED    = 2'd3;

	logic      clk;
	logic      arst_n;
	logic      cmd_valid;
	logic      cmd_ready;
	pfcs_in_t  cmd_item;
	logic      res_valid;
	logic      res_ready;
	pfcs_out_t res_item;
	int        mismatches;
	int        pending;

	int send_idle_pct = 6;
	int recv_idle_pct = 59;
	bit hold_req      = 1'b0;
	int n_sent        = 0;
	int n_noise       = 0;
	int n_prog        = 0;
	int n_erase       = 0;
	int n_id          = 0;
	int n_broken      = 0;

	parallel_flash_command_sequencer_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_item  (cmd_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item)
	);

	pfcs_checker chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.cmd_item   (cmd_item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item),
		.mismatches (mismatches),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// called and returns at a falling edge; valid stays high between back-to-back items
	task automatic offer(logic [1:0] c, logic [ADDR_W-1:0] a, logic [7:0] d);
		pfcs_in_t it;
		it.cmd        = c;
		it.flash_addr = a;
		it.data       = d;
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_item  <= it;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (!cmd_ready)
			@(posedge clk);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic ret(logic [7:0] d);
		offer(CMD_RETURN, ADDR_W'($urandom), d);
	endtask

	// commands that arrive while a sequence waits for its reads
	task automatic busy_noise();
		if ($urandom_range(9) == 0) begin
			n_noise++;
			case ($urandom_range(2))
				0: offer(CMD_PROGRAM, ADDR_W'($urandom), 8'($urandom));
				1: offer(CMD_READ_ID, ADDR_W'($urandom), 8'($urandom));
				default: offer(CMD_UNUSED, ADDR_W'($urandom), 8'($urandom));
			endcase
		end
	endtask

	task automatic toggle_pair(bit toggling);
		logic [7:0] a;
		logic [7:0] b;
		a    = 8'($urandom);
		b    = 8'($urandom);
		b[6] = a[6] ^ toggling;
		busy_noise();
		ret(a);
		busy_noise();
		ret(b);
	endtask

	task automatic settle();
		int polls;
		polls = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
		repeat (polls)
			toggle_pair(1'b1);
		toggle_pair(1'b0);
	endtask

	task automatic program_flash(logic [ADDR_W-1:0] a, logic [7:0] d);
		offer(CMD_PROGRAM, a, d);
		n_prog++;
		if ((a & SECT_MASK) == '0) begin
			n_erase++;
			settle();
		end
		settle();
	endtask

	task automatic read_id(logic [7:0] mk, logic [7:0] ch);
		offer(CMD_READ_ID, ADDR_W'($urandom), 8'($urandom));
		n_id++;
		busy_noise();
		ret(mk);
		busy_noise();
		ret(ch);
	endtask

	// cut a sequence short with random returns, then enough zero returns
	// to bring the block back to idle from any phase
	task automatic broken_sequence();
		logic [ADDR_W-1:0] a;
		n_broken++;
		a = ADDR_W'($urandom);
		if ($urandom_range(1) == 0)
			a = a & ~SECT_MASK;
		if ($urandom_range(1) == 0)
			offer(CMD_PROGRAM, a, 8'($urandom));
		else
			offer(CMD_READ_ID, a, 8'($urandom));
		repeat ($urandom_range(3, 1))
			ret(8'($urandom));
		repeat (6)
			ret(8'h00);
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
	endtask

	// receiver side, with one long hold-off on request
	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_req = 1'b0;
			end
			res_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		int                stage;
		int                useful;
		bit                held;
		logic [ADDR_W-1:0] a;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd_item  = '0;
		stage     = 0;
		held      = 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// stray return and unused code while idle
		n_noise += 2;
		ret(8'hFF);
		offer(CMD_UNUSED, 19'h7FFFF, 8'hFF);
		// erase at address zero: one toggling poll, busy commands while programming
		offer(CMD_PROGRAM, '0, 8'hFF);
		n_prog++;
		n_erase++;
		ret(8'h40);
		ret(8'h00);
		ret(8'h00);
		ret(8'h00);
		n_noise += 3;
		offer(CMD_PROGRAM, 19'h12345, 8'h5A);
		offer(CMD_READ_ID, '0, 8'h00);
		offer(CMD_UNUSED, '0, 8'h00);
		ret(8'hFF);
		ret(8'hFF);
		// last byte of the top bank, toggling once
		offer(CMD_PROGRAM, 19'h7FFFF, 8'h00);
		n_prog++;
		ret(8'hBF);
		ret(8'hFF);
		ret(8'h00);
		ret(8'hBF);
		read_id(8'h00, 8'hFF);
		// sector start in the top bank
		offer(CMD_PROGRAM, 19'h7F000, 8'h55);
		n_prog++;
		n_erase++;
		ret(8'hFF);
		ret(8'hFF);
		ret(8'h00);
		ret(8'h00);

		useful = n_sent - n_noise;
		while (useful < ITEMS) begin
			if (useful * 3 / ITEMS != stage) begin
				stage = useful * 3 / ITEMS;
				drain();
				send_idle_pct = (stage == 1) ? 59 : 0;
				recv_idle_pct = (stage == 1) ? 6 : 0;
			end
			if (!held && useful >= HOLD_AT) begin
				held     = 1'b1;
				hold_req = 1'b1;
			end
			case ($urandom_range(99)) inside
				[0:49]: begin
					a = ADDR_W'($urandom);
					if ($urandom_range(3) == 0)
						a = a & ~SECT_MASK;
					program_flash(a, 8'($urandom));
				end
				[50:74]: read_id(8'($urandom), 8'($urandom));
				[75:84]: begin
					n_noise++;
					ret(8'($urandom));
				end
				[85:91]: begin
					n_noise++;
					offer(CMD_UNUSED, ADDR_W'($urandom), 8'($urandom));
				end
				default: broken_sequence();
			endcase
			useful = n_sent - n_noise;
		end

		drain();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		$display("covered %0d command transactions: %0d byte programs (%0d with sector erase),",
			n_sent, n_prog, n_erase);
		$display("  %0d id reads, %0d cut-short sequences, %0d ignored busy/stray/unused items",
			n_id, n_broken, n_noise);
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
